/* rtl/bank_port_reservation_table_macros.svh */
// ----------------------------------------------------------------------------
// bank port reservation table assertion macros
// shared property forms, used inside modules that have clk and rst_n
// ----------------------------------------------------------------------------
`ifndef BANK_PORT_RESERVATION_TABLE_MACROS_SVH
`define BANK_PORT_RESERVATION_TABLE_MACROS_SVH

// condition must hold at every edge outside reset
`define BPRT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bprt assertion failed");

// antecedent implies consequent in the same cycle
`define BPRT_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bprt assertion failed");

// antecedent implies consequent in the next cycle
`define BPRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bprt assertion failed");

`endif

/* rtl/bprt_pkg.sv */
// ----------------------------------------------------------------------------
// bprt_pkg
// types and codes shared by the reservation table and its slot cells
// ----------------------------------------------------------------------------
package bprt_pkg;

    // width of one port use count
    localparam int CNT_W  = 4;
    // width of the pending read count
    localparam int PEND_W = 6;

    // request modes
    localparam logic [2:0] MODE_TICK        = 3'd0;
    localparam logic [2:0] MODE_READ_CHECK  = 3'd1;
    localparam logic [2:0] MODE_READ_ALLOC  = 3'd2;
    localparam logic [2:0] MODE_WRITE_CHECK = 3'd3;
    localparam logic [2:0] MODE_WRITE_ALLOC = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_READ_PORTS       = 2'd0;
    localparam logic [1:0] CFG_WRITE_PORTS      = 2'd1;
    localparam logic [1:0] CFG_UNLIMITED_READS  = 2'd2;
    localparam logic [1:0] CFG_UNLIMITED_WRITES = 2'd3;

    // input item
    typedef struct packed {
        logic [2:0]        mode;
        logic [1:0]        bank;
        logic [2:0]        first_slot;
        logic [2:0]        end_slot;
        logic [PEND_W-1:0] read_count;
    } bprt_in_t;

    // result item
    typedef struct packed {
        logic granted;
        logic error;
    } bprt_out_t;

    // control broadcast to every slot cell
    typedef struct packed {
        logic             tick;
        logic             commit;
        logic             is_read;
        logic [1:0]       bank;
        logic [2:0]       first_slot;
        logic [2:0]       end_slot;
        logic [CNT_W-1:0] rd_limit;
        logic [CNT_W-1:0] wr_limit;
    } bprt_ctrl_t;

    // request token handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic [PEND_W-1:0] pending;
        logic              hit;
    } bprt_token_t;

endpackage

/* rtl/bprt_slot_cell.sv */
// ----------------------------------------------------------------------------
// bprt_slot_cell
// one time slot of every bank: read and write port use counts, greedy fill
// step for a passing token, shift from the upper neighbor on tick
// ----------------------------------------------------------------------------
module bprt_slot_cell
    import bprt_pkg::*;
#(
    parameter int BANK_COUNT = 4,
    parameter int SLOT       = 0
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  bprt_ctrl_t                         ctrl,
    input  bprt_token_t                        tok_in,
    output bprt_token_t                        tok_out,
    input  logic [BANK_COUNT-1:0][CNT_W-1:0]   up_rd,
    input  logic [BANK_COUNT-1:0][CNT_W-1:0]   up_wr,
    output logic [BANK_COUNT-1:0][CNT_W-1:0]   rd_use,
    output logic [BANK_COUNT-1:0][CNT_W-1:0]   wr_use
);

    localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

    logic [BANK_COUNT-1:0][CNT_W-1:0] rd_reg, rd_next;
    logic [BANK_COUNT-1:0][CNT_W-1:0] wr_reg, wr_next;
    bprt_token_t                      tok_reg, tok_next;
    logic [CNT_W-1:0]                 take_reg, take_next;
    logic                             wtake_reg, wtake_next;

    logic [BANK_W-1:0] bidx;
    logic [CNT_W-1:0]  cur_rd;
    logic [CNT_W-1:0]  cur_wr;
    logic [CNT_W-1:0]  free_ports;
    logic [CNT_W-1:0]  take;
    logic              in_window;
    logic              wr_match;
    logic              wr_room;

    // addressed bank counts
    assign bidx   = BANK_W'(ctrl.bank);
    assign cur_rd = rd_reg[bidx];
    assign cur_wr = wr_reg[bidx];

    // slot position against the request
    assign in_window = (SLOT >= int'(ctrl.first_slot)) && (SLOT < int'(ctrl.end_slot));
    assign wr_match  = (SLOT == int'(ctrl.first_slot));
    assign wr_room   = (cur_wr < ctrl.wr_limit);

    // greedy fill step
    assign free_ports = (cur_rd < ctrl.rd_limit) ? (ctrl.rd_limit - cur_rd) : '0;
    assign take = (tok_in.pending < {{(PEND_W-CNT_W){1'b0}}, free_ports}) ?
                  tok_in.pending[CNT_W-1:0] : free_ports;

    // token update and tentative claims
    always_comb
    begin
        tok_next   = tok_in;
        take_next  = take_reg;
        wtake_next = wtake_reg;
        if (tok_in.vld)
        begin
            take_next  = '0;
            wtake_next = 1'b0;
            if (ctrl.is_read)
            begin
                if (in_window)
                begin
                    take_next        = take;
                    tok_next.pending = tok_in.pending - {{(PEND_W-CNT_W){1'b0}}, take};
                end
            end
            else if (wr_match && wr_room)
            begin
                wtake_next   = 1'b1;
                tok_next.hit = 1'b1;
            end
        end
    end

    // count update: shift on tick, add claims on commit
    always_comb
    begin
        rd_next = rd_reg;
        wr_next = wr_reg;
        if (ctrl.tick)
        begin
            rd_next = up_rd;
            wr_next = up_wr;
        end
        else if (ctrl.commit)
        begin
            if (ctrl.is_read)
            begin
                rd_next[bidx] = cur_rd + take_reg;
            end
            else if (wtake_reg)
            begin
                wr_next[bidx] = cur_wr + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            tok_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            tok_reg <= tok_next;
        end
    end

    // claims are payload, rewritten by every token
    always_ff @(posedge clk)
    begin
        take_reg  <= take_next;
        wtake_reg <= wtake_next;
    end

    assign tok_out = tok_reg;
    assign rd_use  = rd_reg;
    assign wr_use  = wr_reg;

endmodule

/* rtl/bank_port_reservation_table.sv */
// ----------------------------------------------------------------------------
// bank_port_reservation_table
// per-bank read and write port reservations over a window of future slots,
// kept in a row of slot cells that a request token walks through
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+------------------------------
//  in       | in_valid, in_ready, in_data      | request item into the block
//  out      | out_valid, out_ready, out_data   | granted / error result out
//  cfg      | cfg_valid, cfg_ready, cfg_index, | register writes, always ready
//           | cfg_data                         |
//
//  tick, unlimited modes, bank out of range and unused modes: result is
//  registered the cycle after the transfer, next request taken right away.
//  read and write requests: the token starts from start_reg and walks all
//  WINDOW_SLOTS cells, one per cycle; the result is registered when it leaves
//  the last cell, where an allocate commits, or held while the output is full.
//  one request in flight; in_ready is low while a token walks the row or a
//  result waits for a full output register.
//  reset clears all counts, registers to 1, 1, 0, 0; no clearing pass.
// ----------------------------------------------------------------------------
`include "bank_port_reservation_table_macros.svh"

module bank_port_reservation_table
    import bprt_pkg::*;
#(
    parameter int BANK_COUNT   = 4,
    parameter int WINDOW_SLOTS = 8,
    parameter int MAX_PORTS    = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  bprt_in_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output bprt_out_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             start_reg, start_next;
    bprt_in_t         req_reg, req_next;
    bprt_out_t        res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    bprt_out_t        out_reg, out_next;
    logic [CNT_W-1:0] read_ports_reg;
    logic [CNT_W-1:0] write_ports_reg;
    logic             unl_reads_reg;
    logic             unl_writes_reg;

    logic                             in_xfer;
    logic                             out_free;
    logic                             bank_ok;
    logic                             imm;
    bprt_out_t                        imm_res;
    logic                             req_is_read;
    logic                             req_alloc;
    logic                             fits;
    logic                             exit_vld;
    bprt_out_t                        chain_res;
    bprt_ctrl_t                       ctrl;
    bprt_token_t                      tok_chain [WINDOW_SLOTS+1];
    logic [BANK_COUNT-1:0][CNT_W-1:0] rd_use [WINDOW_SLOTS];
    logic [BANK_COUNT-1:0][CNT_W-1:0] wr_use [WINDOW_SLOTS];
    logic [WINDOW_SLOTS-1:0]          tok_vld_vec;

    // handshakes
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_ports_reg  <= CNT_W'(1);
            write_ports_reg <= CNT_W'(1);
            unl_reads_reg   <= 1'b0;
            unl_writes_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_READ_PORTS:       read_ports_reg  <= cfg_data;
                CFG_WRITE_PORTS:      write_ports_reg <= cfg_data;
                CFG_UNLIMITED_READS:  unl_reads_reg   <= cfg_data[0];
                CFG_UNLIMITED_WRITES: unl_writes_reg  <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // requests answered without walking the row
    assign bank_ok = int'(in_data.bank) < BANK_COUNT;

    always_comb
    begin
        imm     = 1'b1;
        imm_res = '0;
        case (in_data.mode)
            MODE_TICK:
            begin
                imm_res.granted = 1'b1;
            end
            MODE_READ_CHECK, MODE_READ_ALLOC:
            begin
                if (unl_reads_reg)
                begin
                    imm_res.granted = 1'b1;
                end
                else if (!bank_ok)
                begin
                    imm_res.error = (in_data.mode == MODE_READ_ALLOC);
                end
                else
                begin
                    imm = 1'b0;
                end
            end
            MODE_WRITE_CHECK, MODE_WRITE_ALLOC:
            begin
                if (unl_writes_reg)
                begin
                    imm_res.granted = 1'b1;
                end
                else if (!bank_ok)
                begin
                    imm_res.error = (in_data.mode == MODE_WRITE_ALLOC);
                end
                else
                begin
                    imm = 1'b0;
                end
            end
            default:
            begin
                imm_res = '0;
            end
        endcase
    end

    // held request decode
    assign req_is_read = (req_reg.mode == MODE_READ_CHECK) ||
                         (req_reg.mode == MODE_READ_ALLOC);
    assign req_alloc   = (req_reg.mode == MODE_READ_ALLOC) ||
                         (req_reg.mode == MODE_WRITE_ALLOC);

    // token leaving the last cell
    assign exit_vld          = tok_chain[WINDOW_SLOTS].vld;
    assign fits              = req_is_read ? (tok_chain[WINDOW_SLOTS].pending == '0) :
                                             tok_chain[WINDOW_SLOTS].hit;
    assign chain_res.granted = fits;
    assign chain_res.error   = req_alloc && !fits;

    // control broadcast to the cells
    always_comb
    begin
        ctrl.tick       = in_xfer && (in_data.mode == MODE_TICK);
        ctrl.commit     = exit_vld && req_alloc && fits;
        ctrl.is_read    = req_is_read;
        ctrl.bank       = req_reg.bank;
        ctrl.first_slot = req_reg.first_slot;
        ctrl.end_slot   = req_reg.end_slot;
        ctrl.rd_limit   = (int'(read_ports_reg) < MAX_PORTS) ? read_ports_reg :
                                                               CNT_W'(MAX_PORTS);
        ctrl.wr_limit   = (int'(write_ports_reg) < MAX_PORTS) ? write_ports_reg :
                                                                CNT_W'(MAX_PORTS);
    end

    // token enters the first cell
    always_comb
    begin
        tok_chain[0].vld     = start_reg;
        tok_chain[0].pending = req_reg.read_count;
        tok_chain[0].hit     = 1'b0;
    end

    // row of slot cells
    for (genvar s = 0; s < WINDOW_SLOTS; s++)
    begin : g_cell
        logic [BANK_COUNT-1:0][CNT_W-1:0] up_rd;
        logic [BANK_COUNT-1:0][CNT_W-1:0] up_wr;

        if (s == WINDOW_SLOTS - 1)
        begin : g_top
            assign up_rd = '0;
            assign up_wr = '0;
        end
        else
        begin : g_mid
            assign up_rd = rd_use[s+1];
            assign up_wr = wr_use[s+1];
        end

        bprt_slot_cell #(
            .BANK_COUNT (BANK_COUNT),
            .SLOT       (s)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .tok_in  (tok_chain[s]),
            .tok_out (tok_chain[s+1]),
            .up_rd   (up_rd),
            .up_wr   (up_wr),
            .rd_use  (rd_use[s]),
            .wr_use  (wr_use[s])
        );

        assign tok_vld_vec[s] = tok_chain[s+1].vld;
    end

    // sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        req_next       = req_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next = in_data;
                    if (imm)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = imm_res;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        start_next = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (exit_vld)
                begin
                    res_next = chain_res;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = chain_res;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // at most one token in the row
    `BPRT_ASSERT_ALWAYS(a_one_token, $onehot0({start_reg, tok_vld_vec}))
    // a token only leaves the row while the sequencer runs
    `BPRT_ASSERT_IMPLIES(a_exit_in_run, exit_vld, state_reg == ST_RUN)
    // waiting for the output means a result is still held there
    `BPRT_ASSERT_IMPLIES(a_wait_full, state_reg == ST_WAIT, out_valid_reg)
    // an error result is never also a grant
    `BPRT_ASSERT_IMPLIES(a_err_no_grant, out_valid_reg, !(out_reg.granted && out_reg.error))
    // a commit is followed by a presented or held result
    `BPRT_ASSERT_NEXT(a_commit_result, ctrl.commit, out_valid_reg || state_reg == ST_WAIT)

endmodule

/* tb/bank_port_reservation_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_port_reservation_table_tb
// self-checking bench for the bank port reservation table: a directed table
// of requests, then random phases under several port settings and idling
// patterns, each result compared against its typed value or an in-bench predictor
// ----------------------------------------------------------------------------
module bank_port_reservation_table_tb;
    import bprt_pkg::*;

    localparam int TB_BANKS      = 4;
    localparam int TB_SLOTS      = 8;
    localparam int TB_MAX_PORTS  = 8;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_ITEMS   = 90;
    localparam int NUM_DIRECTED  = 21;
    localparam int CYCLE_LIMIT   = 200000;

    // one directed row: request, whether the result is typed in, and that result
    typedef struct packed {
        bprt_in_t  req;
        logic      typed;
        bprt_out_t res;
    } directed_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    bprt_in_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    bprt_out_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_READ_PORTS;
    logic [3:0] cfg_data  = '0;

    // predictor state: port use counts and register copies
    logic [3:0] read_ports_used  [TB_BANKS][TB_SLOTS];
    logic [3:0] write_ports_used [TB_BANKS][TB_SLOTS];
    logic [3:0] read_ports_cfg       = 4'd1;
    logic [3:0] write_ports_cfg      = 4'd1;
    logic       unlimited_reads_cfg  = 1'b0;
    logic       unlimited_writes_cfg = 1'b0;

    bprt_out_t     expected_grants [$];
    bprt_out_t     arrived_want;
    directed_row_t directed [NUM_DIRECTED];
    int            send_idle_pct  = 0;
    int            out_stall_pct  = 0;
    int            mismatch_count = 0;
    int unsigned   cycle_count    = 0;

    bank_port_reservation_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL bank_port_reservation_table");
            $finish;
        end
    end

    // result side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: result with none expected, actual granted=%0b error=%0b",
                         $time, out_data.granted, out_data.error);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                arrived_want = expected_grants.pop_front();
                if (out_data.granted !== arrived_want.granted)
                begin
                    $display("%0t: granted mismatch, expected %0b actual %0b",
                             $time, arrived_want.granted, out_data.granted);
                    mismatch_count = mismatch_count + 1;
                end
                if (out_data.error !== arrived_want.error)
                begin
                    $display("%0t: error mismatch, expected %0b actual %0b",
                             $time, arrived_want.error, out_data.error);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // reservation predictor: updates the use counts and returns the result
    function automatic bprt_out_t predict_reservation(input bprt_in_t req);
        bprt_out_t res;
        logic      alloc;
        int        rd_lim;
        int        wr_lim;
        int        need;
        int        avail;
        int        take;
        int        s;
        int        b;
        res    = '0;
        alloc  = (req.mode == MODE_READ_ALLOC) || (req.mode == MODE_WRITE_ALLOC);
        rd_lim = (read_ports_cfg < TB_MAX_PORTS) ? read_ports_cfg : TB_MAX_PORTS;
        wr_lim = (write_ports_cfg < TB_MAX_PORTS) ? write_ports_cfg : TB_MAX_PORTS;
        case (req.mode)
            MODE_TICK:
            begin
                // every window moves down one slot, top slot cleared
                for (b = 0; b < TB_BANKS; b++)
                begin
                    for (s = 0; s < TB_SLOTS - 1; s++)
                    begin
                        read_ports_used[b][s]  = read_ports_used[b][s + 1];
                        write_ports_used[b][s] = write_ports_used[b][s + 1];
                    end
                    read_ports_used[b][TB_SLOTS - 1]  = '0;
                    write_ports_used[b][TB_SLOTS - 1] = '0;
                end
                res.granted = 1'b1;
            end
            MODE_READ_CHECK, MODE_READ_ALLOC:
            begin
                if (unlimited_reads_cfg)
                    res.granted = 1'b1;
                else
                begin
                    // greedy fill over the window
                    need = req.read_count;
                    for (s = req.first_slot; s < req.end_slot && s < TB_SLOTS; s++)
                    begin
                        avail = (read_ports_used[req.bank][s] < rd_lim) ?
                                rd_lim - read_ports_used[req.bank][s] : 0;
                        need  = (need > avail) ? need - avail : 0;
                    end
                    if (need == 0)
                    begin
                        res.granted = 1'b1;
                        if (alloc)
                        begin
                            need = req.read_count;
                            for (s = req.first_slot;
                                 s < req.end_slot && s < TB_SLOTS && need > 0; s++)
                            begin
                                avail = (read_ports_used[req.bank][s] < rd_lim) ?
                                        rd_lim - read_ports_used[req.bank][s] : 0;
                                take  = (need < avail) ? need : avail;
                                read_ports_used[req.bank][s] =
                                    read_ports_used[req.bank][s] + take[3:0];
                                need  = need - take;
                            end
                        end
                    end
                    else
                        res.error = alloc;
                end
            end
            MODE_WRITE_CHECK, MODE_WRITE_ALLOC:
            begin
                if (unlimited_writes_cfg)
                    res.granted = 1'b1;
                else if (write_ports_used[req.bank][req.first_slot] < wr_lim)
                begin
                    res.granted = 1'b1;
                    if (alloc)
                        write_ports_used[req.bank][req.first_slot] =
                            write_ports_used[req.bank][req.first_slot] + 4'd1;
                end
                else
                    res.error = alloc;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic directed_row_t dir_row(input logic [2:0] mode, input logic [1:0] bank,
                                              input logic [2:0] first, input logic [2:0] last,
                                              input logic [5:0] count, input logic typed,
                                              input logic granted, input logic error);
        directed_row_t row;
        row.req.mode       = mode;
        row.req.bank       = bank;
        row.req.first_slot = first;
        row.req.end_slot   = last;
        row.req.read_count = count;
        row.typed          = typed;
        row.res.granted    = granted;
        row.res.error      = error;
        return row;
    endfunction

    // mostly well-formed read and write requests, some ticks and unused modes
    function automatic bprt_in_t random_request();
        bprt_in_t req;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 12)
            req.mode = MODE_TICK;
        else if (pick < 17)
            req.mode = 3'($urandom_range(7, 5));
        else
            req.mode = 3'($urandom_range(4, 1));
        req.bank       = 2'($urandom_range(3));
        req.first_slot = 3'($urandom_range(7));
        if ($urandom_range(9) < 8)
            req.end_slot = 3'($urandom_range(7, req.first_slot));
        else
            req.end_slot = 3'($urandom_range(7));
        if ($urandom_range(9) < 8)
            req.read_count = 6'($urandom_range(12));
        else
            req.read_count = 6'($urandom_range(63));
        return req;
    endfunction

    // one request transfer, then its expected result is queued
    task automatic issue_request(input bprt_in_t req, input logic typed,
                                 input bprt_out_t typed_res);
        bprt_out_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        predicted = predict_reservation(req);
        expected_grants.insert(expected_grants.size(), typed ? typed_res : predicted);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
    endtask

    // one register write transfer, then the predictor copy follows
    task automatic write_register(input logic [1:0] idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_READ_PORTS:       read_ports_cfg       = val;
            CFG_WRITE_PORTS:      write_ports_cfg      = val;
            CFG_UNLIMITED_READS:  unlimited_reads_cfg  = val[0];
            CFG_UNLIMITED_WRITES: unlimited_writes_cfg = val[0];
            default: ;
        endcase
    endtask

    initial
    begin
        int         i;
        int         ph;
        logic [3:0] rp;
        logic [3:0] wp;
        logic       ur;
        logic       uw;

        for (i = 0; i < TB_BANKS * TB_SLOTS; i++)
        begin
            read_ports_used[i / TB_SLOTS][i % TB_SLOTS]  = '0;
            write_ports_used[i / TB_SLOTS][i % TB_SLOTS] = '0;
        end

        // directed table, run with the reset settings of one port each
        directed[0]  = dir_row(MODE_TICK,        2'd0, 3'd0, 3'd0, 6'd0,  1'b1, 1'b1, 1'b0);
        // zero count always fits
        directed[1]  = dir_row(MODE_READ_CHECK,  2'd0, 3'd0, 3'd7, 6'd0,  1'b1, 1'b1, 1'b0);
        // too many reads for the window
        directed[2]  = dir_row(MODE_READ_CHECK,  2'd3, 3'd0, 3'd7, 6'd63, 1'b1, 1'b0, 1'b0);
        directed[3]  = dir_row(MODE_READ_ALLOC,  2'd3, 3'd0, 3'd7, 6'd63, 1'b1, 1'b0, 1'b1);
        // empty window
        directed[4]  = dir_row(MODE_READ_ALLOC,  2'd0, 3'd5, 3'd2, 6'd0,  1'b1, 1'b1, 1'b0);
        directed[5]  = dir_row(MODE_READ_CHECK,  2'd0, 3'd7, 3'd7, 6'd1,  1'b1, 1'b0, 1'b0);
        // fill bank 1 then probe it
        directed[6]  = dir_row(MODE_READ_ALLOC,  2'd1, 3'd0, 3'd7, 6'd7,  1'b0, 1'b0, 1'b0);
        directed[7]  = dir_row(MODE_READ_CHECK,  2'd1, 3'd0, 3'd7, 6'd1,  1'b0, 1'b0, 1'b0);
        directed[8]  = dir_row(MODE_WRITE_CHECK, 2'd2, 3'd7, 3'd0, 6'd0,  1'b1, 1'b1, 1'b0);
        // claim the top write slot until full
        directed[9]  = dir_row(MODE_WRITE_ALLOC, 2'd2, 3'd7, 3'd0, 6'd0,  1'b0, 1'b0, 1'b0);
        directed[10] = dir_row(MODE_WRITE_ALLOC, 2'd2, 3'd7, 3'd0, 6'd0,  1'b0, 1'b0, 1'b0);
        directed[11] = dir_row(MODE_WRITE_CHECK, 2'd2, 3'd7, 3'd0, 6'd0,  1'b0, 1'b0, 1'b0);
        // tick with every other field at its top
        directed[12] = dir_row(MODE_TICK,        2'd3, 3'd7, 3'd7, 6'd63, 1'b1, 1'b1, 1'b0);
        directed[13] = dir_row(MODE_WRITE_CHECK, 2'd2, 3'd6, 3'd0, 6'd0,  1'b0, 1'b0, 1'b0);
        directed[14] = dir_row(MODE_READ_ALLOC,  2'd1, 3'd6, 3'd7, 6'd1,  1'b0, 1'b0, 1'b0);
        // unused modes
        directed[15] = dir_row(3'd5,             2'd0, 3'd0, 3'd0, 6'd0,  1'b1, 1'b0, 1'b0);
        directed[16] = dir_row(3'd6,             2'd1, 3'd3, 3'd4, 6'd5,  1'b1, 1'b0, 1'b0);
        directed[17] = dir_row(3'd7,             2'd3, 3'd7, 3'd7, 6'd63, 1'b1, 1'b0, 1'b0);
        directed[18] = dir_row(MODE_READ_ALLOC,  2'd0, 3'd2, 3'd5, 6'd3,  1'b0, 1'b0, 1'b0);
        directed[19] = dir_row(MODE_READ_CHECK,  2'd2, 3'd0, 3'd1, 6'd2,  1'b0, 1'b0, 1'b0);
        directed[20] = dir_row(MODE_WRITE_ALLOC, 2'd0, 3'd0, 3'd0, 6'd0,  1'b0, 1'b0, 1'b0);

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++)
            issue_request(directed[i].req, directed[i].typed, directed[i].res);

        // random phases, each with its own port settings and idling
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin rp = 4'd1;  wp = 4'd1;  ur = 1'b0; uw = 1'b0; end
                1: begin rp = 4'd8;  wp = 4'd8;  ur = 1'b0; uw = 1'b0; end
                2: begin rp = 4'd15; wp = 4'd15; ur = 1'b0; uw = 1'b0; end
                3: begin rp = 4'd3;  wp = 4'd2;  ur = 1'b1; uw = 1'b0; end
                4: begin rp = 4'd2;  wp = 4'd4;  ur = 1'b0; uw = 1'b1; end
                5: begin rp = 4'd8;  wp = 4'd1;  ur = 1'b0; uw = 1'b0; end
                default: begin rp = 4'd1; wp = 4'd8; ur = 1'b1; uw = 1'b1; end
            endcase
            case (ph)
                1, 4:    begin send_idle_pct = 46; out_stall_pct = 0;  end
                2, 5:    begin send_idle_pct = 0;  out_stall_pct = 46; end
                3, 6:    begin send_idle_pct = 30; out_stall_pct = 30; end
                default: begin send_idle_pct = 0;  out_stall_pct = 0;  end
            endcase
            wait_results_drained();
            write_register(CFG_READ_PORTS, rp);
            write_register(CFG_WRITE_PORTS, wp);
            write_register(CFG_UNLIMITED_READS, {3'b000, ur});
            write_register(CFG_UNLIMITED_WRITES, {3'b000, uw});
            cfg_valid <= 1'b0;
            for (i = 0; i < PHASE_ITEMS; i++)
                issue_request(random_request(), 1'b0, '0);
        end

        // drain and let the block settle
        wait_results_drained();
        repeat (TB_SLOTS + 4) @(posedge clk);
        if (mismatch_count == 0 && expected_grants.size() == 0)
            $display("PASS bank_port_reservation_table");
        else
            $display("FAIL bank_port_reservation_table");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/bprt_pkg.sv
rtl/bprt_slot_cell.sv
rtl/bank_port_reservation_table.sv
tb/bank_port_reservation_table_tb.sv
